[src/tdpt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tdpt_pkg;

  // default width of the number datapath
  localparam int NUM_WIDTH_DEF = 32;

  // width of the candidate port
  localparam int CAND_WIDTH = 32;

  // smallest prime, the first trial divisor and the divisor stride
  localparam int SMALLEST_PRIME = 2;
  localparam int FIRST_DIVISOR  = 3;
  localparam int DIVISOR_STEP   = 2;

endpackage

`default_nettype wire

[src/trial_division_prime_test.sv]
`timescale 1ns / 1ps
`default_nettype none

// Trial-division primality test.
// Input channel: drive candidate and raise start; the word is taken at a rising
// edge where start is high and busy is low. busy stays high while a test runs.
// Output channel: done is high for exactly one cycle with is_prime valid beside
// it; the receiver cannot stall, so the result must be taken in that cycle.
// Zero, one, two and even candidates answer in the cycle after start.
// An odd candidate of three or more tries odd divisors 3, 5, 7, ... while the
// divisor does not exceed candidate / divisor; each divisor takes one full
// division in the bit-serial divider (one quotient bit per cycle) and then a
// check. A prime near 2^32 needs about 32768 divisors; a composite stops at
// its smallest odd factor.
// Throughput: one candidate at a time; a new start may be given in the cycle
// done is high. Only the low NUM_WIDTH bits of candidate are tested.
// Reset (rst, synchronous, active high) abandons any test under way, clears
// busy and done; no result is given for an abandoned candidate.
module trial_division_prime_test #(
  parameter int NUM_WIDTH = tdpt_pkg::NUM_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [tdpt_pkg::CAND_WIDTH-1:0] candidate,
  output logic                                 busy,
  output logic                                 done,
  output logic                                 is_prime
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  logic [63:0]          cand_ext;
  logic [NUM_WIDTH-1:0] cand_n;
  logic [NUM_WIDTH-1:0] num;
  logic [NUM_WIDTH-1:0] dvr;
  logic [NUM_WIDTH-1:0] dvr_next;
  logic                 div_go;
  logic                 div_done;
  logic [NUM_WIDTH-1:0] quo;
  logic [NUM_WIDTH-1:0] rem;
  logic                 accept;
  logic                 simple;
  logic                 simple_prime;
  logic                 found;
  logic                 bound_hit;
  logic                 done_next;
  logic                 prime_next;

  assign cand_ext = 64'(candidate);
  assign cand_n   = cand_ext[NUM_WIDTH-1:0];
  assign accept   = start & ~busy;
  assign busy     = (state == S_RUN);

  // below three, or even: answered without division
  assign simple       = (cand_n < NUM_WIDTH'(tdpt_pkg::FIRST_DIVISOR)) | ~cand_n[0];
  assign simple_prime = (cand_n == NUM_WIDTH'(tdpt_pkg::SMALLEST_PRIME));

  assign bound_hit = (quo < dvr);
  assign found     = (rem == '0);

  always_comb begin
    state_next = state;
    dvr_next   = dvr;
    div_go     = 1'b0;
    done_next  = 1'b0;
    prime_next = is_prime;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (simple) begin
            done_next  = 1'b1;
            prime_next = simple_prime;
          end else begin
            dvr_next   = NUM_WIDTH'(tdpt_pkg::FIRST_DIVISOR);
            div_go     = 1'b1;
            state_next = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (div_done) begin
          // bound checked before the remainder, as the loop does
          priority if (bound_hit) begin
            done_next  = 1'b1;
            prime_next = 1'b1;
            state_next = S_IDLE;
          end else if (found) begin
            done_next  = 1'b1;
            prime_next = 1'b0;
            state_next = S_IDLE;
          end else begin
            dvr_next = dvr + NUM_WIDTH'(tdpt_pkg::DIVISOR_STEP);
            div_go   = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    dvr      <= dvr_next;
    is_prime <= prime_next;
    if (accept) begin
      num <= cand_n;
    end
  end

  tdpt_div #(
    .NUM_WIDTH(NUM_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend ((state == S_IDLE) ? cand_n : num),
    .divisor  (dvr_next),
    .done     (div_done),
    .quotient (quo),
    .remainder(rem)
  );

endmodule

`default_nettype wire

[src/tdpt_div.sv]
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle, MSB first.
module tdpt_div #(
  parameter int NUM_WIDTH = tdpt_pkg::NUM_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 go,
  input  wire logic [NUM_WIDTH-1:0] dividend,
  input  wire logic [NUM_WIDTH-1:0] divisor,
  output logic                      done,
  output logic [NUM_WIDTH-1:0]      quotient,
  output logic [NUM_WIDTH-1:0]      remainder
);

  localparam int CW = $clog2(NUM_WIDTH + 1);

  logic                 run;
  logic [CW-1:0]        cnt;
  logic [NUM_WIDTH-1:0] dvs;
  logic [NUM_WIDTH:0]   trial;
  logic [NUM_WIDTH:0]   diff;
  logic                 qbit;

  // dividend bits leave the top of the quotient register as quotient bits fill the bottom
  assign trial = {remainder, quotient[NUM_WIDTH-1]};
  assign diff  = trial - {1'b0, dvs};
  assign qbit  = ~diff[NUM_WIDTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= CW'(NUM_WIDTH);
      end else if (run) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (run) begin
      quotient  <= {quotient[NUM_WIDTH-2:0], qbit};
      remainder <= qbit ? diff[NUM_WIDTH-1:0] : trial[NUM_WIDTH-1:0];
    end
  end

endmodule

`default_nettype wire
